### sv/sem_pkg.sv
// sketch entity mirror: shared widths, register indexes, kind codes and helpers
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
package sem_pkg;

    localparam int COORD_W    = 32;
    localparam int ANGLE_W    = 24;
    localparam int RADIUS_W   = 31;
    localparam int ID_W       = 16;
    localparam int KIND_W     = 3;
    localparam int OKIND_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // line direction after range folding, |d| <= 2^30
    localparam int DIR_W   = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int KW      = 63;              // ca = dx^2 - dy^2, cb = 2 dx dy
    localparam int LEN_W   = 62;              // dx^2 + dy^2
    localparam int SPLIT   = 31;              // low part of a coefficient
    localparam int PROD_W  = (KW - SPLIT) + DIFF_W;
    localparam int NUM_W   = 97;
    localparam int QB      = 34;              // quotient bits, |q| < 2^33
    localparam int MAG_W   = LEN_W + QB;
    localparam int SAT_IN_W = QB + 2;
    localparam int LANE_LAT = 6 + QB + 2;

    localparam int MAX_STEPS = 24;
    localparam int CNT_W     = 5;
    localparam int CX_W      = 34;
    localparam int ZW        = 26;
    localparam int PI_Q16    = 205887;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_START_X = 3'd0;
    localparam t_cfg_idx REG_START_Y = 3'd1;
    localparam t_cfg_idx REG_END_X   = 3'd2;
    localparam t_cfg_idx REG_END_Y   = 3'd3;
    localparam t_cfg_idx REG_MODE    = 3'd4;
    localparam t_cfg_idx REG_SKIP_EN = 3'd5;
    localparam t_cfg_idx REG_SKIP_ID = 3'd6;

    localparam logic [KIND_W-1:0] K_POINT  = 3'd0;
    localparam logic [KIND_W-1:0] K_LINE   = 3'd1;
    localparam logic [KIND_W-1:0] K_CIRCLE = 3'd2;
    localparam logic [KIND_W-1:0] K_ARC    = 3'd3;

    localparam logic [OKIND_W-1:0] OK_LINE = 2'd1;
    localparam logic [OKIND_W-1:0] OK_ARC  = 2'd3;

    typedef struct packed {
        logic signed [KW-1:0] ca;
        logic signed [KW-1:0] cb;
        logic [LEN_W-1:0]     den;
        logic                 zero;
    } t_coef;

    // atan(2^-i) in Q.16
    function automatic logic [15:0] atan_q16(input logic [CNT_W-1:0] i);
        logic [15:0] v;
        unique case (i)
            5'd0:  v = 16'd51472;
            5'd1:  v = 16'd30386;
            5'd2:  v = 16'd16055;
            5'd3:  v = 16'd8150;
            5'd4:  v = 16'd4091;
            5'd5:  v = 16'd2047;
            5'd6:  v = 16'd1024;
            5'd7:  v = 16'd512;
            5'd8:  v = 16'd256;
            5'd9:  v = 16'd128;
            5'd10: v = 16'd64;
            5'd11: v = 16'd32;
            5'd12: v = 16'd16;
            5'd13: v = 16'd8;
            5'd14: v = 16'd4;
            5'd15: v = 16'd2;
            5'd16: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SAT_IN_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[SAT_IN_W-1:COORD_W-1] == '0 || v[SAT_IN_W-1:COORD_W-1] == '1) begin
            r = v[COORD_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [ZW-1:0] v);
        logic signed [ANGLE_W-1:0] r;
        if (v[ZW-1:ANGLE_W-1] == '0 || v[ZW-1:ANGLE_W-1] == '1) begin
            r = v[ANGLE_W-1:0];
        end else if (v[ZW-1]) begin
            r = {1'b1, {(ANGLE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### sv/sketch_entity_mirror.sv
// sketch entity mirror top level: configuration registers, line setup,
// two reflection lanes and the merge stage; depends on sem_pkg, sem_lane, sem_cordic
`timescale 1ns / 1ps
// Takes one sketch entity (point, line, circle or arc) per cycle and gives its
// mirror image from the merge output register, marked by o_valid for one cycle;
// entities that produce nothing (unknown kind, skipped id, arc in point mode)
// simply leave that slot empty. Two lanes reflect the entity's two points in
// parallel, each through a 42-stage pipeline set by the 34-stage divider.
// The receiver cannot stall, so items are never held back by the output.
// busy is high after reset and after any write to a line endpoint register,
// while the line angle is recomputed one cordic step per cycle; no item is
// accepted then.
module sketch_entity_mirror import sem_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic [ID_W-1:0]           i_item_id,
    input  logic signed [COORD_W-1:0] i_ax,
    input  logic signed [COORD_W-1:0] i_ay,
    input  logic signed [COORD_W-1:0] i_bx,
    input  logic signed [COORD_W-1:0] i_by,
    input  logic [RADIUS_W-1:0]       i_radius,
    input  logic signed [ANGLE_W-1:0] i_angle_start,
    input  logic signed [ANGLE_W-1:0] i_angle_end,
    input  logic                      i_construction,
    output logic                      o_valid,
    output logic [OKIND_W-1:0]        o_out_kind,
    output logic signed [COORD_W-1:0] o_out_ax,
    output logic signed [COORD_W-1:0] o_out_ay,
    output logic signed [COORD_W-1:0] o_out_bx,
    output logic signed [COORD_W-1:0] o_out_by,
    output logic [RADIUS_W-1:0]       o_out_radius,
    output logic signed [ANGLE_W-1:0] o_out_angle_start,
    output logic signed [ANGLE_W-1:0] o_out_angle_end,
    output logic                      o_out_construction
);

    typedef struct packed {
        logic [OKIND_W-1:0]        kind;
        logic [RADIUS_W-1:0]       radius;
        logic signed [ANGLE_W-1:0] as;
        logic signed [ANGLE_W-1:0] ae;
        logic                      cons;
    } t_side;

    logic signed [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic                      r_mode, r_skip_en, r_load;
    logic [ID_W-1:0]           r_skip_id;

    logic signed [DIFF_W-1:0] dfx, dfy, h1x, h1y, h2x, h2y;
    logic signed [DIR_W-1:0]  dx, dy;
    logic signed [2*DIR_W-1:0] r_sxx, r_syy, r_sxy;
    t_coef                    r_coef;

    logic                      accept, keep, cordic_busy;
    logic signed [ANGLE_W-1:0] line_angle;
    logic                      r_vld  [LANE_LAT];
    t_side                     r_side [LANE_LAT];
    t_side                     side_in, side_end;

    logic signed [COORD_W-1:0] ra_x, ra_y, rb_x, rb_y;
    logic signed [ZW-1:0]      ang_s, ang_e;
    logic                      is_line, is_arc;

    logic                      r_valid, r_cons;
    logic [OKIND_W-1:0]        r_kind;
    logic signed [COORD_W-1:0] r_oax, r_oay, r_obx, r_oby;
    logic [RADIUS_W-1:0]       r_orad;
    logic signed [ANGLE_W-1:0] r_oas, r_oae;

    function automatic logic in_dir_range(input logic signed [DIFF_W-1:0] v);
        return (v <= $signed(DIFF_W'(1 << 30))) && (v >= -$signed(DIFF_W'(1 << 30)));
    endfunction

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx      <= '0;
            r_sy      <= '0;
            r_ex      <= '0;
            r_ey      <= COORD_W'(65536);
            r_mode    <= 1'b0;
            r_skip_en <= 1'b0;
            r_skip_id <= '0;
            r_load    <= 1'b1;
        end else begin
            r_load <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_START_X: begin r_sx <= i_cfg_data; r_load <= 1'b1; end
                    REG_START_Y: begin r_sy <= i_cfg_data; r_load <= 1'b1; end
                    REG_END_X:   begin r_ex <= i_cfg_data; r_load <= 1'b1; end
                    REG_END_Y:   begin r_ey <= i_cfg_data; r_load <= 1'b1; end
                    REG_MODE:    r_mode    <= i_cfg_data[0];
                    REG_SKIP_EN: r_skip_en <= i_cfg_data[0];
                    REG_SKIP_ID: r_skip_id <= i_cfg_data[ID_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // line direction, halved until both parts are within 2^30
    assign dfx = DIFF_W'(r_ex) - DIFF_W'(r_sx);
    assign dfy = DIFF_W'(r_ey) - DIFF_W'(r_sy);
    assign h1x = dfx >>> 1;
    assign h1y = dfy >>> 1;
    assign h2x = dfx >>> 2;
    assign h2y = dfy >>> 2;

    always_comb begin
        priority if (in_dir_range(dfx) && in_dir_range(dfy)) begin
            dx = dfx[DIR_W-1:0];
            dy = dfy[DIR_W-1:0];
        end else if (in_dir_range(h1x) && in_dir_range(h1y)) begin
            dx = h1x[DIR_W-1:0];
            dy = h1y[DIR_W-1:0];
        end else begin
            dx = h2x[DIR_W-1:0];
            dy = h2y[DIR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sxx       <= dx * dx;
        r_syy       <= dy * dy;
        r_sxy       <= dx * dy;
        r_coef.ca   <= KW'(r_sxx) - KW'(r_syy);
        r_coef.cb   <= KW'(r_sxy) <<< 1;
        r_coef.den  <= LEN_W'(r_sxx + r_syy);
        r_coef.zero <= (r_sxx + r_syy) == '0;
    end

    sem_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_load),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_angle (line_angle),
        .o_busy  (cordic_busy)
    );

    assign busy   = r_load | cordic_busy;
    assign accept = start & ~busy;

    always_comb begin
        keep = i_kind <= K_ARC;
        if (!r_mode && r_skip_en && i_item_id == r_skip_id) begin
            keep = 1'b0;
        end
        if (r_mode && i_kind == K_ARC) begin
            keep = 1'b0;
        end
    end

    assign side_in.kind   = i_kind[OKIND_W-1:0];
    assign side_in.radius = i_radius;
    assign side_in.as     = i_angle_start;
    assign side_in.ae     = i_angle_end;
    assign side_in.cons   = i_construction;

    // item bookkeeping that travels alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept & keep;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= side_in;
        for (int k = 1; k < LANE_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    sem_lane u_lane_a (
        .i_clk  (i_clk),
        .i_px   (i_ax),
        .i_py   (i_ay),
        .i_sx   (r_sx),
        .i_sy   (r_sy),
        .i_coef (r_coef),
        .i_mode (r_mode),
        .o_rx   (ra_x),
        .o_ry   (ra_y)
    );

    sem_lane u_lane_b (
        .i_clk  (i_clk),
        .i_px   (i_bx),
        .i_py   (i_by),
        .i_sx   (r_sx),
        .i_sy   (r_sy),
        .i_coef (r_coef),
        .i_mode (r_mode),
        .o_rx   (rb_x),
        .o_ry   (rb_y)
    );

    // merge
    assign side_end = r_side[LANE_LAT-1];
    assign is_line  = side_end.kind == OK_LINE;
    assign is_arc   = side_end.kind == OK_ARC;
    assign ang_s    = (ZW'(line_angle) <<< 1) - ZW'(side_end.ae);
    assign ang_e    = (ZW'(line_angle) <<< 1) - ZW'(side_end.as);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= side_end.kind;
        r_oax  <= ra_x;
        r_oay  <= ra_y;
        r_obx  <= is_line ? rb_x : '0;
        r_oby  <= is_line ? rb_y : '0;
        r_orad <= side_end.kind[1] ? side_end.radius : '0;
        r_oas  <= is_arc ? sat_angle(ang_s) : '0;
        r_oae  <= is_arc ? sat_angle(ang_e) : '0;
        r_cons <= is_line & side_end.cons;
    end

    assign o_valid            = r_valid;
    assign o_out_kind         = r_kind;
    assign o_out_ax           = r_oax;
    assign o_out_ay           = r_oay;
    assign o_out_bx           = r_obx;
    assign o_out_by           = r_oby;
    assign o_out_radius       = r_orad;
    assign o_out_angle_start  = r_oas;
    assign o_out_angle_end    = r_oae;
    assign o_out_construction = r_cons;

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind != OK_LINE |->
            o_out_bx == '0 && o_out_by == '0 && !o_out_construction)
        else $error("line-only fields set on a non-line item");

    a_angle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind != OK_ARC |->
            o_out_angle_start == '0 && o_out_angle_end == '0)
        else $error("angle fields set on a non-arc item");

    a_line_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == REG_START_X || i_cfg_idx == REG_START_Y ||
                     i_cfg_idx == REG_END_X || i_cfg_idx == REG_END_Y) |=> busy)
        else $error("line write did not hold off items during angle update");

endmodule

### sv/sem_divider.sv
// pipelined restoring divider, one quotient bit per stage
// depends on sem_pkg
`timescale 1ns / 1ps
module sem_divider import sem_pkg::*; (
    input  logic              i_clk,
    input  logic [MAG_W-1:0]  i_mag,
    input  logic              i_neg,
    input  logic [LEN_W-1:0]  i_den,
    output logic [QB-1:0]     o_q,
    output logic [LEN_W-1:0]  o_rem,
    output logic              o_neg
);

    logic [LEN_W-1:0] r_rem [QB];
    logic [QB-1:0]    r_low [QB];
    logic [QB-1:0]    r_q   [QB];
    logic             r_neg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [LEN_W-1:0] rem_in;
        logic [QB-1:0]    low_in;
        logic [QB-1:0]    q_in;
        logic             neg_in;
        logic [LEN_W:0]   trial;
        logic [LEN_W:0]   diff;
        logic             take;
        logic [LEN_W-1:0] n_rem;
        logic [QB-1:0]    n_q;

        if (k == 0) begin : g_first
            // the quotient fits in QB bits, so the top part is already below den
            assign rem_in = i_mag[MAG_W-1:QB];
            assign low_in = i_mag[QB-1:0];
            assign q_in   = '0;
            assign neg_in = i_neg;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
            assign neg_in = r_neg[k-1];
        end

        assign trial = {rem_in, low_in[QB-1-k]};
        assign diff  = trial - {1'b0, i_den};
        assign take  = trial >= {1'b0, i_den};
        assign n_rem = take ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        assign n_q   = {q_in[QB-2:0], take};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_low[k] <= low_in;
            r_q[k]   <= n_q;
            r_neg[k] <= neg_in;
        end
    end

    assign o_q   = r_q[QB-1];
    assign o_rem = r_rem[QB-1];
    assign o_neg = r_neg[QB-1];

endmodule

### sv/sem_lane.sv
// one reflection lane: offset, split products, numerator sum, two dividers,
// rounding and saturation; depends on sem_pkg and sem_divider
`timescale 1ns / 1ps
module sem_lane import sem_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic signed [COORD_W-1:0] i_sx,
    input  logic signed [COORD_W-1:0] i_sy,
    input  t_coef                     i_coef,
    input  logic                      i_mode,
    output logic signed [COORD_W-1:0] o_rx,
    output logic signed [COORD_W-1:0] o_ry
);

    logic signed [COORD_W-1:0] r_px_dl [LANE_LAT-1];
    logic signed [COORD_W-1:0] r_py_dl [LANE_LAT-1];

    logic signed [DIFF_W-1:0] r_qx, r_qy;
    logic signed [PROD_W-1:0] r_pa_hi_x, r_pa_lo_x, r_pb_hi_y, r_pb_lo_y;
    logic signed [PROD_W-1:0] r_pb_hi_x, r_pb_lo_x, r_pa_hi_y, r_pa_lo_y;
    logic signed [NUM_W-1:0]  r_t_ax, r_t_by, r_t_bx, r_t_ay;
    logic signed [NUM_W-1:0]  r_nx, r_ny;
    logic [MAG_W-1:0]         r_magx, r_magy;
    logic                     r_negx, r_negy;
    logic signed [SAT_IN_W-1:0] r_ox, r_oy;
    logic signed [COORD_W-1:0]  r_rx, r_ry;

    logic signed [KW-SPLIT-1:0] ca_hi, cb_hi;
    logic signed [KW-SPLIT:0]   ca_lo, cb_lo;
    logic signed [NUM_W-1:0]    nx_abs, ny_abs;

    logic [QB-1:0]    qx_q, qy_q;
    logic [LEN_W-1:0] qx_rem, qy_rem;
    logic             qx_neg, qy_neg;
    logic [QB:0]      qrx, qry;

    logic signed [COORD_W-1:0]  px_end, py_end;
    logic signed [SAT_IN_W-1:0] sum_x, sum_y, pm_x, pm_y;
    logic signed [COORD_W-1:0]  n_rx, n_ry;

    assign ca_hi = i_coef.ca[KW-1:SPLIT];
    assign cb_hi = i_coef.cb[KW-1:SPLIT];
    assign ca_lo = $signed({2'b00, i_coef.ca[SPLIT-1:0]});
    assign cb_lo = $signed({2'b00, i_coef.cb[SPLIT-1:0]});

    assign nx_abs = r_nx[NUM_W-1] ? -r_nx : r_nx;
    assign ny_abs = r_ny[NUM_W-1] ? -r_ny : r_ny;

    always_ff @(posedge i_clk) begin
        r_px_dl[0] <= i_px;
        r_py_dl[0] <= i_py;
        for (int k = 1; k < LANE_LAT - 1; k++) begin
            r_px_dl[k] <= r_px_dl[k-1];
            r_py_dl[k] <= r_py_dl[k-1];
        end

        r_qx <= DIFF_W'(r_px_dl[0]) - DIFF_W'(i_sx);
        r_qy <= DIFF_W'(r_py_dl[0]) - DIFF_W'(i_sy);

        r_pa_hi_x <= ca_hi * r_qx;
        r_pa_lo_x <= ca_lo * r_qx;
        r_pb_hi_y <= cb_hi * r_qy;
        r_pb_lo_y <= cb_lo * r_qy;
        r_pb_hi_x <= cb_hi * r_qx;
        r_pb_lo_x <= cb_lo * r_qx;
        r_pa_hi_y <= ca_hi * r_qy;
        r_pa_lo_y <= ca_lo * r_qy;

        r_t_ax <= (NUM_W'(r_pa_hi_x) <<< SPLIT) + NUM_W'(r_pa_lo_x);
        r_t_by <= (NUM_W'(r_pb_hi_y) <<< SPLIT) + NUM_W'(r_pb_lo_y);
        r_t_bx <= (NUM_W'(r_pb_hi_x) <<< SPLIT) + NUM_W'(r_pb_lo_x);
        r_t_ay <= (NUM_W'(r_pa_hi_y) <<< SPLIT) + NUM_W'(r_pa_lo_y);

        r_nx <= r_t_ax + r_t_by;
        r_ny <= r_t_bx - r_t_ay;

        r_negx <= r_nx[NUM_W-1];
        r_negy <= r_ny[NUM_W-1];
        r_magx <= nx_abs[MAG_W-1:0];
        r_magy <= ny_abs[MAG_W-1:0];
    end

    sem_divider u_div_x (
        .i_clk (i_clk),
        .i_mag (r_magx),
        .i_neg (r_negx),
        .i_den (i_coef.den),
        .o_q   (qx_q),
        .o_rem (qx_rem),
        .o_neg (qx_neg)
    );

    sem_divider u_div_y (
        .i_clk (i_clk),
        .i_mag (r_magy),
        .i_neg (r_negy),
        .i_den (i_coef.den),
        .o_q   (qy_q),
        .o_rem (qy_rem),
        .o_neg (qy_neg)
    );

    // round to nearest, ties away from zero
    assign qrx = {1'b0, qx_q} + (QB+1)'({qx_rem, 1'b0} >= {1'b0, i_coef.den});
    assign qry = {1'b0, qy_q} + (QB+1)'({qy_rem, 1'b0} >= {1'b0, i_coef.den});

    assign px_end = r_px_dl[LANE_LAT-2];
    assign py_end = r_py_dl[LANE_LAT-2];
    assign sum_x  = SAT_IN_W'(i_sx) + r_ox;
    assign sum_y  = SAT_IN_W'(i_sy) + r_oy;
    assign pm_x   = (SAT_IN_W'(i_sx) <<< 1) - SAT_IN_W'(px_end);
    assign pm_y   = (SAT_IN_W'(i_sy) <<< 1) - SAT_IN_W'(py_end);

    always_comb begin
        priority if (i_mode) begin
            n_rx = sat_coord(pm_x);
            n_ry = sat_coord(pm_y);
        end else if (i_coef.zero) begin
            n_rx = px_end;
            n_ry = py_end;
        end else begin
            n_rx = sat_coord(sum_x);
            n_ry = sat_coord(sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ox <= qx_neg ? -$signed({1'b0, qrx}) : $signed({1'b0, qrx});
        r_oy <= qy_neg ? -$signed({1'b0, qry}) : $signed({1'b0, qry});
        r_rx <= n_rx;
        r_ry <= n_ry;
    end

    assign o_rx = r_rx;
    assign o_ry = r_ry;

endmodule

### sv/sem_cordic.sv
// iterative vectoring cordic for the mirror line angle, one step per cycle
// depends on sem_pkg
`timescale 1ns / 1ps
module sem_cordic import sem_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic signed [DIR_W-1:0]   i_dx,
    input  logic signed [DIR_W-1:0]   i_dy,
    output logic signed [ANGLE_W-1:0] o_angle,
    output logic                      o_busy
);

    localparam int LAST = ((STEPS < MAX_STEPS) ? STEPS : MAX_STEPS) - 1;

    logic signed [CX_W-1:0]    r_x, r_y, n_x, n_y, xs, ys;
    logic signed [ZW-1:0]      r_z, n_z, at;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_run;
    logic signed [ANGLE_W-1:0] r_angle;

    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;
    assign at = $signed(ZW'(atan_q16(r_cnt)));

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (r_y > 0) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end else if (r_y < 0) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_cnt   <= '0;
            r_angle <= '0;
        end else if (i_load) begin
            r_run <= 1'b1;
            r_cnt <= '0;
            // fold into the right half plane
            if (i_dx < 0) begin
                r_x <= -CX_W'(i_dx);
                r_y <= -CX_W'(i_dy);
                r_z <= (i_dy < 0) ? -ZW'(PI_Q16) : ZW'(PI_Q16);
            end else begin
                r_x <= CX_W'(i_dx);
                r_y <= CX_W'(i_dy);
                r_z <= '0;
            end
        end else if (r_run) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(LAST)) begin
                r_run   <= 1'b0;
                r_angle <= sat_angle(n_z);
            end
        end
    end

    assign o_angle = r_angle;
    assign o_busy  = r_run;

endmodule
